[hw/rtl/rpe_pkg.sv]
package rpe_pkg;

	localparam int BYTE_W     = 8;
	localparam int WORD_BYTES = 8;
	localparam int OUT_W      = BYTE_W * WORD_BYTES;
	localparam int CNT_W      = 4;
	localparam int SLOT_W     = 3;
	localparam int LEN_W      = 8;
	// run limit is this span plus the minimum run length minus one
	localparam int RUN_SPAN   = 128;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_CP_HDR,
		S_CP_DATA,
		S_RUN_HDR,
		S_RUN_VAL,
		S_CLOSE
	} state_t;

	typedef enum logic [1:0] {
		SRC_CP_HDR,
		SRC_CP_DATA,
		SRC_RUN_HDR,
		SRC_RUN_VAL
	} src_t;

	typedef struct packed {
		logic accept;
		logic take_pre;
		logic load_flush;
		logic push;
		src_t src;
		logic close;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic pre_pend;
		logic run_pend;
		logic eos_pend;
		logic flush_left;
		logic cp_last;
		logic byte_ready;
		logic out_free;
	} sts_t;

endpackage

[hw/rtl/rle_packbits_encoder_top.sv]
// an item that yields no encoded bytes is taken without leaving idle, and the next one may follow at once
// an item that yields encoded bytes holds the input off until its bytes are packed and the close state is done:
// the packer takes one byte a cycle unless the output stalls, read one a cycle from the literal ring buffer ram
// a full result is registered as the next byte is packed, the last one in the close state after its byte
// reset (arst_n low) clears counters, run state, packer and output valid; buffer ram is not cleared
module rle_packbits_encoder_top #(
	parameter int MIN_RUN_LEN  = 3,
	parameter int MAX_COPY_LEN = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rpe_pkg::BYTE_W-1:0] in_byte,
	input  logic                       end_of_stream,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rpe_pkg::OUT_W-1:0]  out_bytes,
	output logic [rpe_pkg::CNT_W-1:0]  out_count,
	output logic                       out_last
);

	import rpe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rpe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	rpe_datapath #(
		.MIN_RUN_LEN (MIN_RUN_LEN),
		.MAX_COPY_LEN(MAX_COPY_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_byte      (in_byte),
		.end_of_stream(end_of_stream),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_bytes    (out_bytes),
		.out_count    (out_count),
		.out_last     (out_last)
	);

endmodule

[hw/rtl/rpe_ram.sv]
module rpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/rpe_ctrl.sv]
module rpe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rpe_pkg::sts_t sts,
	output rpe_pkg::cmd_t cmd
);

	import rpe_pkg::*;

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && sts.busy) begin
					state_n = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.pre_pend) begin
					state_n = S_CP_HDR;
				end else if (sts.run_pend) begin
					state_n = S_RUN_HDR;
				end else if (sts.eos_pend && sts.flush_left) begin
					state_n = S_CP_HDR;
				end else begin
					state_n = S_CLOSE;
				end
			end
			S_CP_HDR: begin
				if (sts.byte_ready) begin
					state_n = S_CP_DATA;
				end
			end
			S_CP_DATA: begin
				if (sts.byte_ready && sts.cp_last) begin
					state_n = S_DISPATCH;
				end
			end
			S_RUN_HDR: begin
				if (sts.byte_ready) begin
					state_n = S_RUN_VAL;
				end
			end
			S_RUN_VAL: begin
				if (sts.byte_ready) begin
					state_n = S_DISPATCH;
				end
			end
			S_CLOSE: begin
				if (sts.out_free) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready       = (state_q == S_IDLE);
		cmd.accept     = (state_q == S_IDLE) && in_valid;
		cmd.take_pre   = (state_q == S_DISPATCH) && sts.pre_pend;
		cmd.load_flush = (state_q == S_DISPATCH) && !sts.pre_pend && !sts.run_pend
			&& sts.eos_pend && sts.flush_left;
		cmd.push       = (state_q inside {S_CP_HDR, S_CP_DATA, S_RUN_HDR, S_RUN_VAL})
			&& sts.byte_ready;
		cmd.close      = (state_q == S_CLOSE) && sts.out_free;
		case (state_q)
			S_CP_HDR:  cmd.src = SRC_CP_HDR;
			S_CP_DATA: cmd.src = SRC_CP_DATA;
			S_RUN_HDR: cmd.src = SRC_RUN_HDR;
			S_RUN_VAL: cmd.src = SRC_RUN_VAL;
			default:   cmd.src = SRC_CP_HDR;
		endcase
	end

endmodule

[hw/rtl/rpe_datapath.sv]
module rpe_datapath #(
	parameter int MIN_RUN_LEN  = 3,
	parameter int MAX_COPY_LEN = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rpe_pkg::cmd_t               cmd,
	output rpe_pkg::sts_t               sts,
	input  logic [rpe_pkg::BYTE_W-1:0]  in_byte,
	input  logic                        end_of_stream,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [rpe_pkg::OUT_W-1:0]   out_bytes,
	output logic [rpe_pkg::CNT_W-1:0]   out_count,
	output logic                        out_last
);

	import rpe_pkg::*;

	localparam int READ_LIMIT = MAX_COPY_LEN + MIN_RUN_LEN - 1;
	localparam int RUN_LIMIT  = RUN_SPAN + MIN_RUN_LEN - 1;
	localparam int AW         = $clog2(READ_LIMIT);
	localparam int CW         = AW + 1;
	localparam int DEPTH      = 2 ** AW;
	localparam int SW         = $clog2(MIN_RUN_LEN + 1);

	localparam logic [CW-1:0]    READ_LIM_C = CW'(READ_LIMIT);
	localparam logic [CW-1:0]    MIN_C      = CW'(MIN_RUN_LEN);
	localparam logic [AW-1:0]    MAX_A      = AW'(MAX_COPY_LEN);
	localparam logic [AW-1:0]    KEEP_A     = AW'(MIN_RUN_LEN - 1);
	localparam logic [LEN_W-1:0] MAX_L      = LEN_W'(MAX_COPY_LEN);
	localparam logic [LEN_W-1:0] MIN_L      = LEN_W'(MIN_RUN_LEN);
	localparam logic [LEN_W-1:0] RUN_LIM_L  = LEN_W'(RUN_LIMIT);
	localparam logic [LEN_W-1:0] HDR_BASE   = LEN_W'(MIN_RUN_LEN - 1);
	localparam logic [SW-1:0]    STREAK_MIN = SW'(MIN_RUN_LEN);
	localparam logic [CNT_W-1:0] FULL_CNT   = CNT_W'(WORD_BYTES);

	// literal ring buffer state
	logic [AW-1:0]     base_q;
	logic [AW-1:0]     lit_cnt_q;
	logic [BYTE_W-1:0] last_q;
	logic [SW-1:0]     streak_q;
	logic              in_run_q;
	logic [LEN_W-1:0]  run_len_q;
	logic [BYTE_W-1:0] run_val_q;

	// pending emission
	logic [AW-1:0]     cp_ptr_q;
	logic [LEN_W-1:0]  cp_n_q;
	logic              pre_pend_q;
	logic              run_pend_q;
	logic [BYTE_W-1:0] run_hdr_q;
	logic [BYTE_W-1:0] run_byte_q;
	logic              eos_pend_q;

	// packer and output register
	logic [OUT_W-1:0]  pack_q;
	logic [CNT_W-1:0]  pack_cnt_q;
	logic [OUT_W-1:0]  out_bytes_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_last_q;
	logic              out_valid_q;

	logic              same_run;
	logic [LEN_W-1:0]  len1;
	logic              run_max;
	logic              run_brk;
	logic [AW-1:0]     wp;
	logic [CW-1:0]     cnt1;
	logic [SW-1:0]     streak1;
	logic              trig;
	logic              full;
	logic              pre;
	logic [LEN_W-1:0]  pre_n;
	logic [AW-1:0]     base_n;
	logic [AW-1:0]     lit_cnt_n;
	logic [BYTE_W-1:0] last_n;
	logic [SW-1:0]     streak_n;
	logic              in_run_n;
	logic [LEN_W-1:0]  run_len_n;
	logic [BYTE_W-1:0] run_val_n;
	logic              emit_a;
	logic              emit_b;
	logic [LEN_W-1:0]  len_a;
	logic              ram_we;
	logic [AW-1:0]     fl_n;
	logic              rd_en;
	logic [BYTE_W-1:0] rd_data;
	logic [BYTE_W-1:0] push_byte;
	logic              pack_full;
	logic              out_free;
	logic [OUT_W-1:0]  pack_ins;

	// next state of the buffer and run tracking for the offered item
	always_comb begin
		same_run  = (in_byte == run_val_q);
		len1      = run_len_q + LEN_W'(1);
		run_max   = in_run_q && same_run && (len1 == RUN_LIM_L);
		run_brk   = in_run_q && !same_run;
		wp        = base_q + lit_cnt_q;
		cnt1      = {1'b0, lit_cnt_q} + CW'(1);
		streak1   = (lit_cnt_q != '0 && in_byte == last_q) ? streak_q + SW'(1) : SW'(1);
		trig      = !in_run_q && (streak1 == STREAK_MIN);
		full      = !in_run_q && !trig && (cnt1 == READ_LIM_C);
		pre       = (trig && cnt1 > MIN_C) || full;
		pre_n     = full ? MAX_L : LEN_W'(cnt1 - MIN_C);

		base_n    = base_q;
		lit_cnt_n = lit_cnt_q;
		last_n    = last_q;
		streak_n  = streak_q;
		in_run_n  = in_run_q;
		run_len_n = run_len_q;
		run_val_n = run_val_q;

		if (in_run_q) begin
			if (run_brk) begin
				in_run_n  = 1'b0;
				run_len_n = '0;
				lit_cnt_n = AW'(1);
				last_n    = in_byte;
				streak_n  = SW'(1);
			end else if (run_max) begin
				in_run_n  = 1'b0;
				run_len_n = '0;
			end else begin
				run_len_n = len1;
			end
		end else begin
			last_n = in_byte;
			if (trig) begin
				base_n    = wp + AW'(1);
				lit_cnt_n = '0;
				streak_n  = '0;
				in_run_n  = 1'b1;
				run_len_n = MIN_L;
				run_val_n = in_byte;
			end else if (full) begin
				base_n    = base_q + MAX_A;
				lit_cnt_n = KEEP_A;
				streak_n  = streak1;
			end else begin
				lit_cnt_n = AW'(cnt1);
				streak_n  = streak1;
			end
		end

		emit_a = run_brk || run_max;
		len_a  = run_brk ? run_len_q : len1;
		emit_b = end_of_stream && in_run_n;
		ram_we = cmd.accept && (!in_run_q || run_brk);
	end

	// flush block size and byte source
	always_comb begin
		fl_n      = (lit_cnt_q > MAX_A) ? MAX_A : lit_cnt_q;
		rd_en     = cmd.push && ((cmd.src == SRC_CP_HDR)
			|| (cmd.src == SRC_CP_DATA && cp_n_q != LEN_W'(1)));
		pack_full = (pack_cnt_q == FULL_CNT);
		out_free  = !out_valid_q || out_ready;
		case (cmd.src)
			SRC_CP_HDR:  push_byte = cp_n_q - LEN_W'(1);
			SRC_CP_DATA: push_byte = rd_data;
			SRC_RUN_HDR: push_byte = run_hdr_q;
			SRC_RUN_VAL: push_byte = run_byte_q;
			default:     push_byte = '0;
		endcase
		pack_ins = pack_q | (OUT_W'(push_byte) << {pack_cnt_q[SLOT_W-1:0], 3'b000});
	end

	rpe_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp),
		.wdata(in_byte),
		.re   (rd_en),
		.raddr(cp_ptr_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			lit_cnt_q   <= '0;
			last_q      <= '0;
			streak_q    <= '0;
			in_run_q    <= 1'b0;
			run_len_q   <= '0;
			run_val_q   <= '0;
			cp_ptr_q    <= '0;
			cp_n_q      <= '0;
			pre_pend_q  <= 1'b0;
			run_pend_q  <= 1'b0;
			run_hdr_q   <= '0;
			run_byte_q  <= '0;
			eos_pend_q  <= 1'b0;
			pack_q      <= '0;
			pack_cnt_q  <= '0;
			out_bytes_q <= '0;
			out_count_q <= '0;
			out_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				base_q     <= base_n;
				lit_cnt_q  <= lit_cnt_n;
				last_q     <= last_n;
				cp_ptr_q   <= base_q;
				cp_n_q     <= pre_n;
				pre_pend_q <= pre;
				run_pend_q <= emit_a || emit_b;
				run_hdr_q  <= HDR_BASE - (emit_a ? len_a : run_len_n);
				run_byte_q <= emit_a ? run_val_q : run_val_n;
				eos_pend_q <= end_of_stream;
				if (end_of_stream) begin
					in_run_q  <= 1'b0;
					run_len_q <= '0;
					run_val_q <= '0;
					streak_q  <= '0;
				end else begin
					in_run_q  <= in_run_n;
					run_len_q <= run_len_n;
					run_val_q <= run_val_n;
					streak_q  <= streak_n;
				end
			end
			if (cmd.take_pre) begin
				pre_pend_q <= 1'b0;
			end
			if (cmd.load_flush) begin
				cp_ptr_q  <= base_q;
				cp_n_q    <= LEN_W'(fl_n);
				base_q    <= base_q + fl_n;
				lit_cnt_q <= lit_cnt_q - fl_n;
			end
			if (rd_en) begin
				cp_ptr_q <= cp_ptr_q + AW'(1);
			end
			if (cmd.push && cmd.src == SRC_CP_DATA) begin
				cp_n_q <= cp_n_q - LEN_W'(1);
			end
			if (cmd.push && cmd.src == SRC_RUN_VAL) begin
				run_pend_q <= 1'b0;
			end

			// a full word moves out only when another byte follows it or the item closes
			if ((cmd.push && pack_full) || cmd.close) begin
				out_bytes_q <= pack_q;
				out_count_q <= pack_cnt_q;
				out_last_q  <= cmd.close;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.close) begin
				pack_q     <= '0;
				pack_cnt_q <= '0;
				eos_pend_q <= 1'b0;
			end else if (cmd.push) begin
				if (pack_full) begin
					pack_q     <= OUT_W'(push_byte);
					pack_cnt_q <= CNT_W'(1);
				end else begin
					pack_q     <= pack_ins;
					pack_cnt_q <= pack_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_comb begin
		sts.busy       = pre || emit_a || emit_b || (end_of_stream && lit_cnt_n != '0);
		sts.pre_pend   = pre_pend_q;
		sts.run_pend   = run_pend_q;
		sts.eos_pend   = eos_pend_q;
		sts.flush_left = (lit_cnt_q != '0);
		sts.cp_last    = (cp_n_q == LEN_W'(1));
		sts.byte_ready = !pack_full || out_free;
		sts.out_free   = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_bytes = out_bytes_q;
	assign out_count = out_count_q;
	assign out_last  = out_last_q;

endmodule

[hw/rtl/rpe_checker.sv]
module rpe_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [rpe_pkg::BYTE_W-1:0] in_byte,
	input logic                       end_of_stream,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [rpe_pkg::OUT_W-1:0]  out_bytes,
	input logic [rpe_pkg::CNT_W-1:0]  out_count,
	input logic                       out_last
);

	import rpe_pkg::*;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WORD_BYTES);

	logic [OUT_W-1:0] pad_bits;

	// bytes above the count must be zero
	assign pad_bits = out_bytes >> {out_count, 3'b000};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_count != '0 && out_count <= FULL_CNT))
		else $error("result byte count out of range");

	a_zero_pad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pad_bits == '0))
		else $error("unused result bytes not zero");

	a_full_unless_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_last) |-> (out_count == FULL_CNT))
		else $error("non-final result item not full");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_bytes)
			&& $stable(out_count) && $stable(out_last)))
		else $error("stalled result item changed");

endmodule

bind rle_packbits_encoder_top rpe_checker u_rpe_checker (.*);
